/* sv/bod_pkg.sv */
package bod_pkg;

    // Default accumulator depth: one entry per block row of the tallest image.
    localparam int MAX_ROWS_DEF = 1024;

    // Largest block edge in pixels; block counters are sized from it.
    localparam int MAX_BLOCK = 16;
    localparam int BLK_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    localparam int LABEL_W   = 8;
    localparam int COL_W     = 16;
    localparam int OUT_ROW_W = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values, before clamping.
    localparam int IMAGE_ROWS_RST = 1024;
    localparam int IMAGE_COLS_RST = 1024;
    localparam int BLOCK_RST      = 2;

    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [BLK_W-1:0]   blk_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS = 2'd0,
        CFG_IMAGE_COLS = 2'd1,
        CFG_BLOCK_ROWS = 2'd2,
        CFG_BLOCK_COLS = 2'd3
    } cfg_idx_t;

    // Block size minus one; zero acts as one, oversize saturates.
    function automatic blk_t block_limit(input logic [4:0] v);
        blk_t r;
        if (v == 5'd0) begin
            r = '0;
        end else if (int'(v) > MAX_BLOCK) begin
            r = BLK_W'(MAX_BLOCK - 1);
        end else begin
            r = BLK_W'(v - 5'd1);
        end
        return r;
    endfunction

    // Column count minus one; zero acts as one.
    function automatic col_t col_limit(input col_t v);
        col_t r;
        if (v == '0) begin
            r = '0;
        end else begin
            r = v - col_t'(1);
        end
        return r;
    endfunction

endpackage

/* sv/block_or_downsample.sv */
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------------------
// pixel     | pixel_valid / pixel_ready    | pixel_label
// block     | block_valid / block_ready    | block_value, block_row, block_col,
//           |                              | last_of_image
// config    | cfg_en (no wait)             | cfg_addr, cfg_data
//
// One pixel transaction per cycle while pixel_ready is high; a block's closing pixel is
// registered in the merge stage (memory read at the accepting edge), and its OR result
// then loads the output register. After reset the accumulator memory is swept to zero,
// one entry a cycle, over MAX_ROWS entries (1024 by default); pixel_ready stays low
// meanwhile. A stalled output holds its result; pixels that close no block still flow,
// and pixel_ready drops while a block-closing pixel waits in the merge stage.
module block_or_downsample #(
    parameter int MAX_ROWS = bod_pkg::MAX_ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_en,
    input  logic [bod_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [bod_pkg::CFG_W-1:0]    cfg_data,
    // pixel stream in
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  logic [bod_pkg::LABEL_W-1:0]  pixel_label,
    // block results out
    output logic                         block_valid,
    input  logic                         block_ready,
    output logic [bod_pkg::LABEL_W-1:0]  block_value,
    output logic [bod_pkg::OUT_ROW_W-1:0] block_row,
    output logic [bod_pkg::COL_W-1:0]    block_col,
    output logic                         last_of_image
);
    import bod_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLR_W = $clog2(MAX_ROWS + 1);
    localparam int ROWS_M1_RST =
        (IMAGE_ROWS_RST > MAX_ROWS) ? (MAX_ROWS - 1) : (IMAGE_ROWS_RST - 1);

    typedef logic [ROW_W-1:0] row_t;

    // ------------------------------------------------------------------
    // Configuration: stored as clamped limits (size minus one).
    // ------------------------------------------------------------------
    row_t rows_m1_reg;
    col_t cols_m1_reg;
    blk_t br_m1_reg;
    blk_t bc_m1_reg;
    row_t rows_m1_wr;

    always_comb
    begin
        if (cfg_data[10:0] == 11'd0) begin
            rows_m1_wr = '0;
        end else if (int'(cfg_data[10:0]) > MAX_ROWS) begin
            rows_m1_wr = ROW_W'(MAX_ROWS - 1);
        end else begin
            rows_m1_wr = ROW_W'(cfg_data[10:0] - 11'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rows_m1_reg <= ROW_W'(ROWS_M1_RST);
            cols_m1_reg <= col_t'(IMAGE_COLS_RST - 1);
            br_m1_reg   <= BLK_W'(BLOCK_RST - 1);
            bc_m1_reg   <= BLK_W'(BLOCK_RST - 1);
        end else if (cfg_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_IMAGE_ROWS: rows_m1_reg <= rows_m1_wr;
                CFG_IMAGE_COLS: cols_m1_reg <= col_limit(cfg_data);
                CFG_BLOCK_ROWS: br_m1_reg   <= block_limit(cfg_data[4:0]);
                CFG_BLOCK_COLS: bc_m1_reg   <= block_limit(cfg_data[4:0]);
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Power-up sweep of the accumulator memory.
    // ------------------------------------------------------------------
    logic             clearing_reg;
    logic [CLR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_cnt_reg == CLR_W'(MAX_ROWS - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position counters, memory read issue.
    // ------------------------------------------------------------------
    row_t pix_row_reg;
    col_t pix_col_reg;
    blk_t rib_reg;
    blk_t cib_reg;
    row_t cur_brow_reg;
    col_t cur_bcol_reg;

    logic pixel_acc;
    logic col_end;
    logic col_last;
    logic img_end;
    logic row_done;
    logic col_done;

    // merge stage handshake
    logic s1_valid_reg;
    logic s1_adv;

    assign pixel_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign pixel_acc   = pixel_valid && pixel_ready;

    assign col_end  = pix_row_reg >= rows_m1_reg;
    assign col_last = pix_col_reg >= cols_m1_reg;
    assign img_end  = col_end && col_last;
    assign row_done = col_end || (rib_reg >= br_m1_reg);
    assign col_done = col_last || (cib_reg >= bc_m1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pix_row_reg  <= '0;
            pix_col_reg  <= '0;
            rib_reg      <= '0;
            cib_reg      <= '0;
            cur_brow_reg <= '0;
            cur_bcol_reg <= '0;
        end else if (pixel_acc) begin
            if (col_end) begin
                pix_row_reg  <= '0;
                rib_reg      <= '0;
                cur_brow_reg <= '0;
                if (img_end) begin
                    pix_col_reg  <= '0;
                    cib_reg      <= '0;
                    cur_bcol_reg <= '0;
                end else begin
                    pix_col_reg <= pix_col_reg + col_t'(1);
                    if (cib_reg >= bc_m1_reg) begin
                        cib_reg      <= '0;
                        cur_bcol_reg <= cur_bcol_reg + col_t'(1);
                    end else begin
                        cib_reg <= cib_reg + blk_t'(1);
                    end
                end
            end else begin
                pix_row_reg <= pix_row_reg + row_t'(1);
                if (rib_reg >= br_m1_reg) begin
                    rib_reg      <= '0;
                    cur_brow_reg <= cur_brow_reg + row_t'(1);
                end else begin
                    rib_reg <= rib_reg + blk_t'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Accumulator memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    label_t acc_mem [MAX_ROWS];
    label_t rd_data_reg;
    logic   mem_we;
    row_t   mem_waddr;
    label_t mem_wdata;

    // merge stage payload
    label_t s1_label_reg;
    row_t   s1_idx_reg;
    col_t   s1_col_reg;
    logic   s1_done_reg;
    logic   s1_last_reg;

    // last write-back, for a read that raced it
    logic   fwd_valid_reg;
    row_t   fwd_idx_reg;
    label_t fwd_data_reg;

    label_t acc_old;
    label_t acc_merged;

    assign acc_old    = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ?
                        fwd_data_reg : rd_data_reg;
    assign acc_merged = acc_old | s1_label_reg;

    always_comb
    begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[ROW_W-1:0];
            mem_wdata = '0;
        end else begin
            mem_we    = s1_adv;
            mem_waddr = s1_idx_reg;
            mem_wdata = s1_done_reg ? '0 : acc_merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            acc_mem[mem_waddr] <= mem_wdata;
        end
        if (pixel_acc) begin
            rd_data_reg <= acc_mem[cur_brow_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: OR merge, write-back, result hand-off.
    // ------------------------------------------------------------------
    logic out_valid_reg;

    assign s1_adv = s1_valid_reg &&
                    (!s1_done_reg || !out_valid_reg || block_ready);

    always_ff @(posedge clk)
    begin
        if (pixel_acc) begin
            s1_label_reg <= pixel_label;
            s1_idx_reg   <= cur_brow_reg;
            s1_col_reg   <= cur_bcol_reg;
            s1_done_reg  <= row_done && col_done;
            s1_last_reg  <= img_end;
        end
        if (mem_we) begin
            fwd_idx_reg  <= mem_waddr;
            fwd_data_reg <= mem_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (pixel_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = s1_adv && s1_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (block_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            block_value   <= acc_merged;
            block_row     <= OUT_ROW_W'(s1_idx_reg);
            block_col     <= s1_col_reg;
            last_of_image <= s1_last_reg;
        end
    end

    assign block_valid = out_valid_reg;

endmodule

/* test/tb.sv */
module tb;
    import bod_pkg::*;

    // Accumulator depth of the instance below (default parameter).
    localparam int unsigned ACC_DEPTH   = MAX_ROWS_DEF;
    localparam int unsigned DRAIN       = 6;     // pipeline is two deep; margin on top
    localparam int unsigned QUIET_LIMIT = 8000;  // covers the post-reset memory sweep
    localparam int unsigned TALL_PIXELS = 320;
    localparam int unsigned RAND_PIXELS = 360;

    // One pooled block as seen on the output channel.
    typedef struct packed {
        label_t                 merged;
        logic [OUT_ROW_W-1:0]   brow;
        col_t                   bcol;
        logic                   is_last;
    } blk_res_t;

    // Directed table row: a register write or a pixel, optionally with a
    // hand-typed expected block.
    typedef struct {
        bit             is_cfg;
        cfg_idx_t       addr;
        logic [CFG_W-1:0] data;
        label_t         lbl;
        bit             typed;
        blk_res_t       want;
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_ready;
    label_t               pixel_label = '0;
    logic                 block_valid;
    logic                 block_ready = 1'b0;
    label_t               block_value;
    logic [OUT_ROW_W-1:0] block_row;
    col_t                 block_col;
    logic                 last_of_image;

    always #4 clk = ~clk;

    block_or_downsample dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_label   (pixel_label),
        .block_valid   (block_valid),
        .block_ready   (block_ready),
        .block_value   (block_value),
        .block_row     (block_row),
        .block_col     (block_col),
        .last_of_image (last_of_image)
    );

    // ------------------------------------------------------------------
    // Pooling predictor: raw register copies (masked to register width,
    // clamped at use) and the scan position / accumulator state.
    // ------------------------------------------------------------------
    logic [10:0] img_rows_q = 11'(IMAGE_ROWS_RST);
    col_t        img_cols_q = col_t'(IMAGE_COLS_RST);
    logic [4:0]  blk_rows_q = 5'(BLOCK_RST);
    logic [4:0]  blk_cols_q = 5'(BLOCK_RST);

    label_t      acc_mem [ACC_DEPTH] = '{default: '0};
    int unsigned pix_row = 0;
    int unsigned pix_col = 0;
    int unsigned row_in_blk = 0;
    int unsigned col_in_blk = 0;
    int unsigned cur_brow = 0;
    int unsigned cur_bcol = 0;

    blk_res_t    blocks_due [$];   // blocks predicted but not yet seen
    int unsigned bad_blocks = 0;

    bit          tx_idle_on = 1'b1;
    bit          rx_stall_on = 1'b1;
    int unsigned ready_hold = 0;
    int unsigned quiet_cycles = 0;

    // Folds one pixel into its block row; returns 1 when the pixel closes a block.
    function automatic bit pool_pixel(input label_t lbl, output blk_res_t res);
        int unsigned rows, cols, br, bc, slot;
        bit col_end, img_end, row_done, col_done, fires;
        // zero sizes act as one, oversize saturates
        rows = (img_rows_q == 0) ? 1 : ((img_rows_q > ACC_DEPTH) ? ACC_DEPTH : img_rows_q);
        cols = (img_cols_q == 0) ? 1 : img_cols_q;
        br   = (blk_rows_q == 0) ? 1 : ((blk_rows_q > MAX_BLOCK) ? MAX_BLOCK : blk_rows_q);
        bc   = (blk_cols_q == 0) ? 1 : ((blk_cols_q > MAX_BLOCK) ? MAX_BLOCK : blk_cols_q);
        slot = cur_brow % ACC_DEPTH;
        // >= compares: counters left past a shrunk limit wrap on their next step
        col_end  = pix_row >= rows - 1;
        img_end  = col_end && pix_col >= cols - 1;
        row_done = col_end || row_in_blk >= br - 1;
        col_done = pix_col >= cols - 1 || col_in_blk >= bc - 1;
        acc_mem[slot] = acc_mem[slot] | lbl;
        res   = '0;
        fires = 1'b0;
        if (row_done && col_done) begin
            res.merged  = acc_mem[slot];
            res.brow    = OUT_ROW_W'(cur_brow);
            res.bcol    = col_t'(cur_bcol);
            res.is_last = img_end;
            acc_mem[slot] = '0;
            fires = 1'b1;
        end
        if (col_end) begin
            pix_row = 0;
            row_in_blk = 0;
            cur_brow = 0;
            if (img_end) begin
                pix_col = 0;
                col_in_blk = 0;
                cur_bcol = 0;
            end else begin
                pix_col++;
                if (col_in_blk >= bc - 1) begin
                    col_in_blk = 0;
                    cur_bcol++;
                end else begin
                    col_in_blk++;
                end
            end
        end else begin
            pix_row++;
            if (row_in_blk >= br - 1) begin
                row_in_blk = 0;
                cur_brow++;
            end else begin
                row_in_blk++;
            end
        end
        return fires;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Sparse labels keep the OR from saturating to all ones.
    function automatic label_t pick_label();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return label_t'(1) << $urandom_range(0, LABEL_W - 1);
        if (r < 60)
            return '0;
        return label_t'($urandom);
    endfunction

    function automatic step_t cfg_row(input cfg_idx_t a, input logic [CFG_W-1:0] d);
        step_t s;
        s = '{is_cfg: 1'b1, addr: a, data: d, lbl: '0, typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic step_t px_row(input label_t l);
        step_t s;
        s = '{is_cfg: 1'b0, addr: CFG_IMAGE_ROWS, data: '0, lbl: l, typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic step_t px_chk(input label_t l, input label_t v, input int unsigned r,
                                     input int unsigned c, input bit lst);
        step_t s;
        s = px_row(l);
        s.typed = 1'b1;
        s.want  = '{v, OUT_ROW_W'(r), col_t'(c), lst};
        return s;
    endfunction

    // Drop valid and hold off until every predicted block has come out.
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (blocks_due.size() != 0);
    endtask

    // Register writes only with the pipeline empty; a pixel that closes no
    // block may still be in flight, hence the extra drain cycles.
    task automatic cfg_write(input cfg_idx_t a, input logic [CFG_W-1:0] d);
        wait_drained();
        repeat (DRAIN) @(posedge clk);
        cfg_en   <= 1'b1;
        cfg_addr <= a;
        cfg_data <= d;
        @(posedge clk);
        cfg_en <= 1'b0;
        case (a)
            CFG_IMAGE_ROWS: img_rows_q = d[10:0];
            CFG_IMAGE_COLS: img_cols_q = d;
            CFG_BLOCK_ROWS: blk_rows_q = d[4:0];
            CFG_BLOCK_COLS: blk_cols_q = d[4:0];
        endcase
    endtask

    // One pixel transaction. A typed expectation overrides the predictor's
    // output for that row; the predictor state still advances.
    task automatic send_pixel(input label_t lbl, input bit typed, input blk_res_t typed_res);
        blk_res_t    res;
        bit          fires;
        int unsigned gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap != 0) begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_label <= lbl;
        do @(posedge clk); while (!pixel_ready);
        fires = pool_pixel(lbl, res);
        if (typed)
            blocks_due.push_back(typed_res);
        else if (fires)
            blocks_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Output side: check each block transaction against the oldest
    // prediction, then pick block_ready for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : block_check
        blk_res_t got;
        blk_res_t want;
        if (rst_n) begin
            if (block_valid && block_ready) begin
                got = '{block_value, block_row, block_col, last_of_image};
                if (blocks_due.size() == 0) begin
                    bad_blocks++;
                    if (bad_blocks <= 10)
                        $display("unexpected block: value %h row %0d col %0d last %0d",
                                 got.merged, got.brow, got.bcol, got.is_last);
                end else begin
                    want = blocks_due.pop_front();
                    if (got.merged !== want.merged || got.brow !== want.brow ||
                        got.bcol !== want.bcol || got.is_last !== want.is_last) begin
                        bad_blocks++;
                        if (bad_blocks <= 10)
                            $display({"block mismatch (exp/act): value %h/%h row %0d/%0d ",
                                      "col %0d/%0d last %0d/%0d"},
                                     want.merged, got.merged, want.brow, got.brow,
                                     want.bcol, got.bcol, want.is_last, got.is_last);
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                block_ready <= 1'b0;
            end else if (rx_stall_on && $urandom_range(0, 9) == 0) begin
                ready_hold = idle_len() - 1;
                block_ready <= 1'b0;
            end else begin
                block_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((pixel_valid && pixel_ready) || (block_valid && block_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        step_t       dir_tab [$];
        int unsigned ir, ic, brv, bcv, rows_e, cols_e, ppi, npix, sent, r;

        // 2x2 image on default 2x2 blocks, then 1x1 blocks written as zero,
        // then oversize blocks (all-ones write masks to 31), then a zero
        // image height, then a height change in the middle of an image
        // (leftover accumulator gets merged into the next block).
        dir_tab = '{
            cfg_row(CFG_IMAGE_ROWS, 16'd2),
            cfg_row(CFG_IMAGE_COLS, 16'd2),
            px_row(8'h01), px_row(8'h02), px_row(8'h04),
            px_chk(8'h80, 8'h87, 0, 0, 1'b1),
            cfg_row(CFG_BLOCK_ROWS, 16'd0),
            cfg_row(CFG_BLOCK_COLS, 16'd0),
            px_chk(8'hFF, 8'hFF, 0, 0, 1'b0),
            px_chk(8'h00, 8'h00, 1, 0, 1'b0),
            px_chk(8'hA5, 8'hA5, 0, 1, 1'b0),
            px_chk(8'h5A, 8'h5A, 1, 1, 1'b1),
            cfg_row(CFG_BLOCK_ROWS, 16'hFFFF),
            cfg_row(CFG_BLOCK_COLS, 16'd17),
            cfg_row(CFG_IMAGE_ROWS, 16'd3),
            px_row(8'h01), px_row(8'h02), px_row(8'h04), px_row(8'h08), px_row(8'h10),
            px_chk(8'h20, 8'h3F, 0, 0, 1'b1),
            cfg_row(CFG_IMAGE_ROWS, 16'd0),
            cfg_row(CFG_IMAGE_COLS, 16'd3),
            cfg_row(CFG_BLOCK_ROWS, 16'd2),
            cfg_row(CFG_BLOCK_COLS, 16'd2),
            px_row(8'h11),
            px_chk(8'h22, 8'h33, 0, 0, 1'b0),
            px_chk(8'h40, 8'h40, 0, 1, 1'b1),
            cfg_row(CFG_IMAGE_ROWS, 16'd4),
            cfg_row(CFG_IMAGE_COLS, 16'd2),
            px_row(8'h03),
            cfg_row(CFG_IMAGE_ROWS, 16'hF801),
            px_row(8'h0C), px_row(8'h30)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg)
                cfg_write(dir_tab[i].addr, dir_tab[i].data);
            else
                send_pixel(dir_tab[i].lbl, dir_tab[i].typed, dir_tab[i].want);
        end

        // Tall single column with one-pixel block rows, cut short: walks the
        // low accumulator entries. Height written as 2047 saturates to the depth.
        cfg_write(CFG_IMAGE_ROWS, 16'hFFFF);
        cfg_write(CFG_IMAGE_COLS, 16'd1);
        cfg_write(CFG_BLOCK_ROWS, 16'd0);
        cfg_write(CFG_BLOCK_COLS, 16'd5);
        repeat (TALL_PIXELS) send_pixel(label_t'($urandom), 1'b0, '0);

        // Random phases: mostly whole small images, sometimes a trailing
        // partial image or a huge width that is never finished.
        sent = 0;
        while (sent < RAND_PIXELS) begin
            r  = $urandom_range(0, 99);
            ir = (r < 70) ? $urandom_range(1, 6) : ((r < 85) ? $urandom_range(7, 40) : 0);
            r  = $urandom_range(0, 99);
            ic = (r < 85) ? $urandom_range(0, 8) :
                 ((r < 92) ? $urandom_range(9, 20) :
                  ((r < 96) ? 16'hFFFF : $urandom_range(1000, 65534)));
            r   = $urandom_range(0, 99);
            brv = (r < 80) ? $urandom_range(1, 8) :
                  ((r < 90) ? $urandom_range(9, 16) : $urandom_range(17, 31) % 32);
            r   = $urandom_range(0, 99);
            bcv = (r < 80) ? $urandom_range(1, 8) :
                  ((r < 90) ? $urandom_range(9, 16) : (r < 95 ? 0 : $urandom_range(17, 31)));
            if ($urandom_range(0, 9) == 0)
                brv = 0;

            // upper data bits past each register's width carry noise
            cfg_write(CFG_IMAGE_ROWS, {5'($urandom), 11'(ir)});
            cfg_write(CFG_IMAGE_COLS, 16'(ic));
            cfg_write(CFG_BLOCK_ROWS, {11'($urandom), 5'(brv)});
            cfg_write(CFG_BLOCK_COLS, {11'($urandom), 5'(bcv)});

            tx_idle_on  = $urandom_range(0, 3) != 0;
            rx_stall_on = $urandom_range(0, 3) != 0;

            rows_e = (ir == 0) ? 1 : ir;
            cols_e = (ic == 0) ? 1 : ic;
            ppi    = rows_e * cols_e;
            if (cols_e > 20) begin
                npix = $urandom_range(1, 30);
            end else begin
                npix = ppi * ((ppi > 60) ? 1 : $urandom_range(1, 3));
                if ($urandom_range(0, 4) == 0)
                    npix += $urandom_range(1, ppi);
            end
            // keep the total near the pixel budget
            if (npix > RAND_PIXELS - sent)
                npix = RAND_PIXELS - sent;

            repeat (npix) begin
                // sender holds off until the output side has caught up
                if (sent == 0 || $urandom_range(0, 59) == 0)
                    wait_drained();
                send_pixel(pick_label(), 1'b0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (DRAIN) @(posedge clk);
        if (bad_blocks == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
